>>> hw/rtl/sha1_stream_hasher_macros.svh
// assertion macros shared by the sha-1 stream hasher modules
// expects clk and arst_n in the scope of each use
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// consequent must hold in the same cycle
`define SHA1S_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define SHA1S_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sha1s_pkg.sv
// shared types and constants for the sha-1 stream hasher
// used by the front queue, the collector, the round engine and the top level
package sha1s_pkg;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic reinit;
	} eng_cmd_t;

	typedef struct packed {
		logic busy;
	} eng_stat_t;

	typedef enum logic [2:0] {
		C_RUN,
		C_MARK,
		C_ZERO,
		C_LEN,
		C_WAIT,
		C_OUT
	} col_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_ROUND,
		E_ADD
	} eng_state_t;

	localparam logic [159:0] H_INIT = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [6:0] PHASE_1    = 7'd20;
	localparam logic [6:0] PHASE_2    = 7'd40;
	localparam logic [6:0] PHASE_3    = 7'd60;
	localparam logic [6:0] ROUNDS     = 7'd80;
	localparam logic [6:0] ROUND_LAST = 7'd79;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd4;

endpackage

>>> hw/rtl/sha1_stream_hasher.sv
// a byte is registered into the queue; a full block is handed to the round unit, which
// then runs 80 rounds and the chaining add
// bytes are taken one per cycle while the previous block compresses, unless the queue
// is empty or a full block waits; the single round unit sets the block rate
// end of message: padding bytes, one or two compressions, then five digest words
// reset: queue empty, chaining words at their initial values, byte count zero
module sha1_stream_hasher import sha1s_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      digest_valid,
	input  logic      digest_stall,
	output out_item_t digest
);

	logic           q_valid;
	in_item_t       q_item;
	logic           q_pop;
	eng_cmd_t       eng_cmd;
	eng_stat_t      eng_stat;
	logic   [511:0] blk;
	logic   [159:0] chain;

	sha1s_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	sha1s_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (eng_cmd),
		.blk    (blk),
		.stat   (eng_stat),
		.chain  (chain)
	);

	sha1s_collect u_collect (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.eng_cmd      (eng_cmd),
		.blk          (blk),
		.eng_stat     (eng_stat),
		.chain        (chain),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule

>>> hw/rtl/sha1s_front.sv
// front end: takes input words, drops empty ones and queues the rest
// depends on sha1s_pkg and sha1_stream_hasher_macros.svh
`include "sha1_stream_hasher_macros.svh"

module sha1s_front import sha1s_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output logic     q_valid,
	output in_item_t q_item,
	input  logic     q_pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	in_item_t          mem_q [DEPTH];
	logic     [PW-1:0] wr_q;
	logic     [PW-1:0] rd_q;
	logic     [CW-1:0] cnt_q;
	logic              push;

	assign item_stall = (cnt_q == CW'(DEPTH));
	assign push       = item_valid && !item_stall && (item.has_byte || item.message_end);
	assign q_valid    = (cnt_q != '0);
	assign q_item     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SHA1S_CHECK_NOW(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
	`SHA1S_CHECK_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "queue count overrun")

endmodule

>>> hw/rtl/sha1s_round.sv
// back end compression unit: one sha-1 round per cycle with a sliding schedule
// holds the chaining words; depends on sha1s_pkg and the assertion macros
`include "sha1_stream_hasher_macros.svh"

module sha1s_round import sha1s_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  eng_cmd_t       cmd,
	input  logic [511:0]   blk,
	output eng_stat_t      stat,
	output logic [159:0]   chain
);

	eng_state_t        est_q;
	eng_state_t        est_d;
	logic        [6:0] rnd_q;
	logic       [31:0] a_q, b_q, c_q, d_q, e_q;
	logic       [31:0] w_q [16];
	logic      [159:0] chain_q;
	logic       [31:0] f;
	logic       [31:0] k;
	logic       [31:0] t;
	logic       [31:0] w_mix;
	logic       [31:0] w_new;

	always_comb begin
		est_d = est_q;
		case (est_q)
			E_IDLE:  if (cmd.load) est_d = E_ROUND;
			E_ROUND: if (rnd_q == ROUND_LAST) est_d = E_ADD;
			E_ADD:   est_d = E_IDLE;
			default: est_d = E_IDLE;
		endcase
	end

	always_comb begin
		if (rnd_q < PHASE_1) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = K_0;
		end else if (rnd_q < PHASE_2) begin
			f = b_q ^ c_q ^ d_q;
			k = K_1;
		end else if (rnd_q < PHASE_3) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_3;
		end
		t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_mix[30:0], w_mix[31]};
		stat.busy = (est_q != E_IDLE);
	end

	assign chain = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q   <= E_IDLE;
			rnd_q   <= '0;
			chain_q <= H_INIT;
		end else begin
			est_q <= est_d;
			if (cmd.load) begin
				rnd_q <= '0;
			end else if (est_q == E_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (cmd.reinit) begin
				chain_q <= H_INIT;
			end else if (est_q == E_ADD) begin
				chain_q <= {chain_q[159:128] + a_q, chain_q[127:96] + b_q,
					chain_q[95:64] + c_q, chain_q[63:32] + d_q, chain_q[31:0] + e_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < 16; j++) begin
				w_q[j] <= blk[511 - 32 * j -: 32];
			end
			a_q <= chain_q[159:128];
			b_q <= chain_q[127:96];
			c_q <= chain_q[95:64];
			d_q <= chain_q[63:32];
			e_q <= chain_q[31:0];
		end else if (est_q == E_ROUND) begin
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j + 1];
			end
			w_q[15] <= w_new;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	`SHA1S_CHECK_NOW(a_round_range, est_q == E_ROUND, rnd_q < ROUNDS, "round count past end")

endmodule

>>> hw/rtl/sha1s_collect.sv
// back end sequencer: gathers bytes into a block, pads, hands blocks to the
// round unit and sends out the digest; depends on sha1s_pkg and the macros
`include "sha1_stream_hasher_macros.svh"

module sha1s_collect import sha1s_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  in_item_t     q_item,
	output logic         q_pop,
	output eng_cmd_t     eng_cmd,
	output logic [511:0] blk,
	input  eng_stat_t    eng_stat,
	input  logic [159:0] chain,
	output logic         digest_valid,
	input  logic         digest_stall,
	output out_item_t    digest
);

	col_state_t         st_q;
	col_state_t         st_d;
	logic       [511:0] buf_q;
	logic         [5:0] pos_q;
	logic        [60:0] total_q;
	logic        [60:0] total_d;
	logic        [63:0] len_q;
	logic               full_q;
	logic         [2:0] idx_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               shift_en;
	logic         [7:0] shift_byte;
	logic               out_load;
	logic        [31:0] word_sel;

	assign total_d = total_q + 61'(q_item.has_byte);

	always_comb begin
		st_d = st_q;
		case (st_q)
			C_RUN:   if (q_valid && !full_q && q_item.message_end) st_d = C_MARK;
			C_MARK:  if (!full_q) st_d = C_ZERO;
			C_ZERO:  if (!full_q && pos_q == LEN_POS) st_d = C_LEN;
			C_LEN:   if (!full_q && pos_q == LAST_POS) st_d = C_WAIT;
			C_WAIT:  if (!full_q && !eng_stat.busy) st_d = C_OUT;
			C_OUT:   if (out_load && idx_q == LAST_IDX) st_d = C_RUN;
			default: st_d = C_RUN;
		endcase
	end

	always_comb begin
		q_pop          = 1'b0;
		shift_en       = 1'b0;
		shift_byte     = '0;
		out_load       = 1'b0;
		case (st_q)
			C_RUN: begin
				if (q_valid && !full_q) begin
					q_pop      = 1'b1;
					shift_en   = q_item.has_byte;
					shift_byte = q_item.data_byte;
				end
			end
			C_MARK: begin
				shift_en   = !full_q;
				shift_byte = PAD_MARK;
			end
			C_ZERO: begin
				shift_en = !full_q && (pos_q != LEN_POS);
			end
			C_LEN: begin
				shift_en   = !full_q;
				shift_byte = len_q[63:56];
			end
			C_OUT: begin
				out_load = !out_valid_q || !digest_stall;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		eng_cmd.load   = full_q && !eng_stat.busy;
		eng_cmd.reinit = out_load && (idx_q == LAST_IDX);
		case (idx_q)
			3'd0:    word_sel = chain[159:128];
			3'd1:    word_sel = chain[127:96];
			3'd2:    word_sel = chain[95:64];
			3'd3:    word_sel = chain[63:32];
			3'd4:    word_sel = chain[31:0];
			default: word_sel = '0;
		endcase
	end

	assign blk          = buf_q;
	assign digest_valid = out_valid_q;
	assign digest       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= C_RUN;
			pos_q       <= '0;
			total_q     <= '0;
			full_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (eng_cmd.reinit) begin
				pos_q <= '0;
			end else if (shift_en) begin
				pos_q <= pos_q + 1'b1;
			end
			if (shift_en && pos_q == LAST_POS) begin
				full_q <= 1'b1;
			end else if (eng_cmd.load) begin
				full_q <= 1'b0;
			end
			if (eng_cmd.reinit) begin
				total_q <= '0;
			end else if (q_pop) begin
				total_q <= total_d;
			end
			if (out_load) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			buf_q <= {buf_q[503:0], shift_byte};
		end
		if (q_pop && q_item.message_end) begin
			len_q <= {total_d, 3'b000};
		end else if (st_q == C_LEN && shift_en) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (out_load) begin
			out_q.digest_word <= word_sel;
			out_q.word_index  <= idx_q;
			out_q.last_word   <= (idx_q == LAST_IDX);
		end
	end

	`SHA1S_CHECK_NOW(a_out_idle, st_q == C_OUT, !eng_stat.busy && !full_q, "digest read mid block")
	`SHA1S_CHECK_NOW(a_len_pos, st_q == C_LEN, pos_q >= LEN_POS, "length field misplaced")
	`SHA1S_CHECK_NEXT(a_load_busy, eng_cmd.load, eng_stat.busy && !full_q, "block load lost")

endmodule
